[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ibd_pkg.sv]
// ---------------------------------------------------------------------------
// ibd_pkg
// Types, flag masks and the field layout function of the indoor bike data
// parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ibd_pkg;

  // Flag word bits that select the optional fields.
  localparam logic [15:0] FLAG_NO_SPEED  = 16'h0001;
  localparam logic [15:0] FLAG_AVG_SPEED = 16'h0002;
  localparam logic [15:0] FLAG_CADENCE   = 16'h0004;
  localparam logic [15:0] FLAG_AVG_CAD   = 16'h0008;
  localparam logic [15:0] FLAG_DISTANCE  = 16'h0010;
  localparam logic [15:0] FLAG_RESIST    = 16'h0020;
  localparam logic [15:0] FLAG_POWER     = 16'h0040;

  // Byte positions.
  localparam logic [4:0] POS_FLAG_LO = 5'd0;
  localparam logic [4:0] POS_FLAG_HI = 5'd1;
  localparam logic [4:0] POS_SPEED   = 5'd2;
  localparam logic [4:0] POS_MAX     = 5'd31;

  // One input byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } ibd_stage_t;

  // Where the captured fields sit for one flag word.
  typedef struct packed {
    logic       has_speed;
    logic       has_cad;
    logic       has_pow;
    logic [4:0] cad_at;
    logic [4:0] pow_at;
    logic [4:0] end_at;
  } layout_t;

  // One parse result.
  typedef struct packed {
    logic               packet_ok;
    logic               speed_present;
    logic        [15:0] speed_raw;
    logic               cadence_present;
    logic        [15:0] cadence_raw;
    logic               power_present;
    logic signed [15:0] power_watts;
  } ibd_result_t;

  // Walk the optional fields in order and note where each captured one starts.
  function automatic layout_t plan(input logic [15:0] f);
    layout_t    l;
    logic [4:0] at;
    at          = POS_SPEED;
    l.has_speed = ((f & FLAG_NO_SPEED) == 16'h0000);
    if (l.has_speed) at = at + 5'd2;
    if ((f & FLAG_AVG_SPEED) != 16'h0000) at = at + 5'd2;
    l.has_cad = ((f & FLAG_CADENCE) != 16'h0000);
    l.cad_at  = at;
    if (l.has_cad) at = at + 5'd2;
    if ((f & FLAG_AVG_CAD) != 16'h0000) at = at + 5'd2;
    if ((f & FLAG_DISTANCE) != 16'h0000) at = at + 5'd3;
    if ((f & FLAG_RESIST) != 16'h0000) at = at + 5'd2;
    l.has_pow = ((f & FLAG_POWER) != 16'h0000);
    l.pow_at  = at;
    if (l.has_pow) at = at + 5'd2;
    l.end_at = at;
    return l;
  endfunction

endpackage

`default_nettype wire

[rtl/ibd_interfaces.sv]
// ---------------------------------------------------------------------------
// ibd_interfaces
// Valid/ready channels for packet bytes and for parse results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ibd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ibd_result_if;
  logic               valid;
  logic               ready;
  logic               packet_ok;
  logic               speed_present;
  logic        [15:0] speed_raw;
  logic               cadence_present;
  logic        [15:0] cadence_raw;
  logic               power_present;
  logic signed [15:0] power_watts;

  modport source (
    output valid, output packet_ok, output speed_present, output speed_raw,
    output cadence_present, output cadence_raw, output power_present,
    output power_watts, input ready
  );
  modport sink (
    input valid, input packet_ok, input speed_present, input speed_raw,
    input cadence_present, input cadence_raw, input power_present,
    input power_watts, output ready
  );
endinterface

`default_nettype wire

[rtl/ibd_in_reg.sv]
// ---------------------------------------------------------------------------
// ibd_in_reg
// Input register: holds one packet byte until the parser core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ibd_in_reg (
  input  wire               clk,
  input  wire               rst_n,
  ibd_byte_if.sink          in_ch,
  input  wire               take,
  output ibd_pkg::ibd_stage_t stage
);
  import ibd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  // A new byte may enter when the register is empty or is being drained.
  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  // Valid flag under reset; payload loads on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.data_byte = data_r;
  assign stage.last_byte = last_r;

endmodule

`default_nettype wire

[rtl/ibd_core.sv]
// ---------------------------------------------------------------------------
// ibd_core
// Parser state, field capture and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ibd_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ibd_pkg::ibd_stage_t stage,
  output logic                take,
  ibd_result_if.source        out_ch
);
  import ibd_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [15:0] cad_r, cad_nxt;
  logic [15:0] pow_r, pow_nxt;
  logic        out_valid_r, out_valid_nxt;
  ibd_result_t result_r, result_nxt;

  layout_t     lay_cur;
  layout_t     lay_new;
  logic [5:0]  len;
  logic        slot_free;
  logic        load;

  // Place a byte into the low or high half of a 16-bit field.
  function automatic logic [15:0] take_byte(input logic [15:0] old, input logic [4:0] pos,
                                            input logic [4:0] at, input logic [7:0] b);
    logic [15:0] v;
    v = old;
    if (pos == at) v = {old[15:8], b};
    else if (pos == at + 5'd1) v = {b, old[7:0]};
    return v;
  endfunction

  // The byte is consumed unless it ends a packet and the result slot is busy.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign take      = stage.valid && (!stage.last_byte || slot_free);
  assign load      = take && stage.last_byte;

  // Field capture for the byte at the current position.
  always_comb begin
    lay_cur   = plan(flag_r);
    flag_nxt  = flag_r;
    speed_nxt = speed_r;
    cad_nxt   = cad_r;
    pow_nxt   = pow_r;
    if (pos_r == POS_FLAG_LO) begin
      flag_nxt = {flag_r[15:8], stage.data_byte};
    end else if (pos_r == POS_FLAG_HI) begin
      flag_nxt = {stage.data_byte, flag_r[7:0]};
    end else begin
      if (lay_cur.has_speed) speed_nxt = take_byte(speed_r, pos_r, POS_SPEED, stage.data_byte);
      if (lay_cur.has_cad)   cad_nxt   = take_byte(cad_r, pos_r, lay_cur.cad_at, stage.data_byte);
      if (lay_cur.has_pow)   pow_nxt   = take_byte(pow_r, pos_r, lay_cur.pow_at, stage.data_byte);
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 5'd1;
  end

  // Result for a packet that ends with this byte.
  always_comb begin
    lay_new    = plan(flag_nxt);
    len        = {1'b0, pos_r} + 6'd1;
    result_nxt = '0;
    if (len >= 6'd2) begin
      result_nxt.packet_ok       = ({1'b0, lay_new.end_at} <= len);
      result_nxt.speed_present   = lay_new.has_speed && ({1'b0, POS_SPEED} + 6'd2 <= len);
      result_nxt.cadence_present = lay_new.has_cad && ({1'b0, lay_new.cad_at} + 6'd2 <= len);
      result_nxt.power_present   = lay_new.has_pow && ({1'b0, lay_new.pow_at} + 6'd2 <= len);
    end
    if (result_nxt.speed_present)   result_nxt.speed_raw   = speed_nxt;
    if (result_nxt.cadence_present) result_nxt.cadence_raw = cad_nxt;
    if (result_nxt.power_present)   result_nxt.power_watts = $signed(pow_nxt);
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Parser state: advances on each consumed byte, clears after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      flag_r      <= '0;
      speed_r     <= '0;
      cad_r       <= '0;
      pow_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (stage.last_byte) begin
          pos_r   <= '0;
          flag_r  <= '0;
          speed_r <= '0;
          cad_r   <= '0;
          pow_r   <= '0;
        end else begin
          pos_r   <= pos_nxt;
          flag_r  <= flag_nxt;
          speed_r <= speed_nxt;
          cad_r   <= cad_nxt;
          pow_r   <= pow_nxt;
        end
      end
    end
  end

  // Result payload loads with each finished packet.
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.packet_ok       = result_r.packet_ok;
  assign out_ch.speed_present   = result_r.speed_present;
  assign out_ch.speed_raw       = result_r.speed_raw;
  assign out_ch.cadence_present = result_r.cadence_present;
  assign out_ch.cadence_raw     = result_r.cadence_raw;
  assign out_ch.power_present   = result_r.power_present;
  assign out_ch.power_watts     = result_r.power_watts;

endmodule

`default_nettype wire

[rtl/indoor_bike_data_parser_top.sv]
// ---------------------------------------------------------------------------
// indoor_bike_data_parser_top
// Parses indoor bike data packets, one byte per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one packet byte per transfer; last_byte marks the final byte.
//   out_ch carries one result per packet, raised after the final byte only:
//   packet_ok, and speed, cadence and power with a present mark each. A field
//   that was not fully received reads as zero.
//   Throughput is one byte per cycle while no final byte waits for the result
//   slot; the only per-byte work is a position compare against the field
//   layout of the flag word and a byte capture. Each byte is registered in
//   the input register, and the result of a packet is registered in the
//   result register once the final byte is taken from the input register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a packet.
//   When the receiver stalls, the result register holds its result; ordinary
//   bytes keep flowing, and a further final byte waits in the input register
//   until the result slot frees up, which then backs up in_ch.ready.
// ---------------------------------------------------------------------------
`default_nettype none

module indoor_bike_data_parser_top (
  input  wire          clk,
  input  wire          rst_n,
  ibd_byte_if.sink     in_ch,
  ibd_result_if.source out_ch
);
  import ibd_pkg::*;

  ibd_stage_t stage;
  logic       take;

  ibd_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  ibd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[rtl/ibd_checker.sv]
// ---------------------------------------------------------------------------
// ibd_checker
// Port-level checks of the indoor bike data parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ibd_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire               packet_ok,
  input wire               speed_present,
  input wire        [15:0] speed_raw,
  input wire               cadence_present,
  input wire        [15:0] cadence_raw,
  input wire               power_present,
  input wire signed [15:0] power_watts
);

  // A stalled result stays offered.
  `ASSERT_CLKD(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `ASSERT_CLKD(a_out_stable, out_valid && !out_ready |=> $stable(packet_ok) && $stable(speed_present) && $stable(speed_raw) && $stable(cadence_present) && $stable(cadence_raw) && $stable(power_present) && $stable(power_watts), "result changed while stalled")

  // With the result slot free, the byte input never blocks.
  `ASSERT_CLKD(a_in_ready, !out_valid || out_ready |-> in_ready, "input blocked with result slot free")

  // Fields that were not received read as zero.
  `ASSERT_CLKD(a_absent_zero, out_valid |-> (speed_present || speed_raw == 16'h0000) && (cadence_present || cadence_raw == 16'h0000) && (power_present || power_watts == 16'sh0000), "absent field not zero")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind indoor_bike_data_parser_top ibd_checker u_ibd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .packet_ok       (out_ch.packet_ok),
  .speed_present   (out_ch.speed_present),
  .speed_raw       (out_ch.speed_raw),
  .cadence_present (out_ch.cadence_present),
  .cadence_raw     (out_ch.cadence_raw),
  .power_present   (out_ch.power_present),
  .power_watts     (out_ch.power_watts)
);

`default_nettype wire
